// ----- sv/palette_index_pixel_expander_defines.svh -----
// assertion macros for the palette index pixel expander
`ifndef PALETTE_INDEX_PIXEL_EXPANDER_DEFINES_SVH
`define PALETTE_INDEX_PIXEL_EXPANDER_DEFINES_SVH

// checked only while out of reset
`define PIE_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// checked at every edge, reset included
`define PIE_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

// ----- sv/pie_pkg.sv -----
package pie_pkg;

  localparam int PaletteEntriesDef = 16;
  localparam int AlphaShiftDef     = 24;

  localparam int EntryIdxW = 4;
  localparam int WordW     = 32;
  localparam int ByteW     = 8;
  localparam int AlphaW    = 8;
  localparam int BufW      = 16;
  localparam int CntW      = 5;
  localparam int BpiW      = 3;
  localparam int IdxW      = 4;
  localparam int CfgIdxW   = 2;
  localparam int CfgDataW  = 8;

  localparam logic [BpiW-1:0]   BpiReset        = 3'd4;
  localparam logic [BpiW-1:0]   BpiMax          = 3'd4;
  localparam logic [AlphaW-1:0] FixedAlphaReset = 8'd255;
  localparam logic [CntW-1:0]   PushLimit       = CntW'(BufW - ByteW);

  typedef enum logic [1:0] {
    KIND_PAL_WR = 2'd0,
    KIND_PUSH   = 2'd1,
    KIND_EMIT   = 2'd2,
    KIND_CLEAR  = 2'd3
  } kind_e;

  typedef enum logic [1:0] {
    STATUS_OK      = 2'd0,
    STATUS_SHORT   = 2'd1,
    STATUS_REFUSED = 2'd2
  } status_e;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_BITS_PER_INDEX  = 2'd0,
    CFG_ALPHA_FROM_ITEM = 2'd1,
    CFG_FIXED_ALPHA     = 2'd2
  } cfg_reg_e;

  typedef struct packed {
    kind_e                kind;
    logic [EntryIdxW-1:0] entry_index;
    logic [WordW-1:0]     entry_word;
    logic [ByteW-1:0]     index_byte;
    logic [AlphaW-1:0]    pixel_alpha;
  } in_item_t;

  typedef struct packed {
    logic [WordW-1:0] pixel_word;
    status_e          status;
  } out_item_t;

  // what the unpacker tells the lookup stage about one item
  typedef struct packed {
    logic            has_result;
    status_e         status;
    logic            rd_en;
    logic [IdxW-1:0] idx;
  } unpack_ctl_t;

endpackage

// ----- sv/palette_index_pixel_expander.sv -----
// a push or emit item shows its result after it passes the palette read register and then the output register
// throughput: one item per cycle while the output is not stalled; palette read (synchronous ram) then output register
// palette writes and clears give no result and take one slot each
// reset clears the bit buffer, fill count and pipeline valids and loads the config reset values
// palette contents are undefined after reset until written
module palette_index_pixel_expander
  import pie_pkg::*;
#(
  parameter int PALETTE_ENTRIES = PaletteEntriesDef,
  parameter int ALPHA_SHIFT     = AlphaShiftDef
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_idx_i,
  input  logic [CfgDataW-1:0] cfg_wdata_i,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  in_item_t            in_item_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output out_item_t           out_item_o
);

  localparam int AddrW = (PALETTE_ENTRIES > 1) ? $clog2(PALETTE_ENTRIES) : 1;

  logic [BpiW-1:0]   bpi_q;
  logic              alpha_from_item_q;
  logic [AlphaW-1:0] fixed_alpha_q;

  logic        accept;
  unpack_ctl_t ctl;

  logic [WordW-1:0] mem [PALETTE_ENTRIES];
  logic [WordW-1:0] rdata_q;
  logic             mem_we;

  logic              s1_valid_q;
  status_e           s1_status_q;
  logic [AlphaW-1:0] s1_alpha_q;
  logic              s1_zero_q;
  logic              s1_advance;
  logic [WordW-1:0]  s1_pixel;

  logic      out_valid_q;
  out_item_t out_item_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bpi_q             <= BpiReset;
      alpha_from_item_q <= 1'b1;
      fixed_alpha_q     <= FixedAlphaReset;
    end else if (cfg_we_i) begin
      case (cfg_reg_e'(cfg_idx_i))
        CFG_BITS_PER_INDEX:  bpi_q             <= cfg_wdata_i[BpiW-1:0];
        CFG_ALPHA_FROM_ITEM: alpha_from_item_q <= cfg_wdata_i[0];
        CFG_FIXED_ALPHA:     fixed_alpha_q     <= cfg_wdata_i[AlphaW-1:0];
        default: begin
          bpi_q <= bpi_q;
        end
      endcase
    end
  end

  // stage 1 moves on whenever the output register is free or being drained
  assign s1_advance = !out_valid_q || out_ready_i;
  assign in_ready_o = !s1_valid_q || s1_advance;
  assign accept     = in_valid_i && in_ready_o;

  pie_unpack u_unpack (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .accept_i         (accept),
    .kind_i           (in_item_i.kind),
    .index_byte_i     (in_item_i.index_byte),
    .bits_per_index_i (bpi_q),
    .ctl_o            (ctl)
  );

  assign mem_we = accept && (in_item_i.kind == KIND_PAL_WR) &&
                  ({1'b0, in_item_i.entry_index} < (EntryIdxW+1)'(PALETTE_ENTRIES));

  // a write lands at its edge, so an emit in the next cycle already sees it
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[in_item_i.entry_index[AddrW-1:0]] <= in_item_i.entry_word;
    end
    if (accept && ctl.rd_en) begin
      rdata_q <= mem[ctl.idx[AddrW-1:0]];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (accept) begin
      s1_valid_q <= ctl.has_result;
    end else if (s1_advance) begin
      s1_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_status_q <= ctl.status;
      s1_alpha_q  <= alpha_from_item_q ? in_item_i.pixel_alpha : fixed_alpha_q;
      // pushes, errors and indices past the palette drop the ram word
      s1_zero_q   <= !ctl.rd_en ||
                     ({1'b0, ctl.idx} >= (IdxW+1)'(PALETTE_ENTRIES));
    end
  end

  always_comb begin
    if (s1_status_q != STATUS_OK) begin
      s1_pixel = '0;
    end else if (s1_zero_q) begin
      s1_pixel = '0;
    end else begin
      s1_pixel = rdata_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (s1_advance) begin
      out_valid_q <= s1_valid_q;
    end
  end

  logic s1_is_emit_q;

  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_is_emit_q <= (in_item_i.kind == KIND_EMIT);
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_advance && s1_valid_q) begin
      out_item_q.status <= s1_status_q;
      if (s1_is_emit_q && (s1_status_q == STATUS_OK)) begin
        out_item_q.pixel_word <= s1_pixel | (WordW'(s1_alpha_q) << ALPHA_SHIFT);
      end else begin
        out_item_q.pixel_word <= '0;
      end
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_item_q;

endmodule

// ----- sv/pie_unpack.sv -----
module pie_unpack
  import pie_pkg::*;
(
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            accept_i,
  input  kind_e           kind_i,
  input  logic [ByteW-1:0] index_byte_i,
  input  logic [BpiW-1:0] bits_per_index_i,
  output unpack_ctl_t     ctl_o
);

  logic [BufW-1:0] buf_q, buf_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic [BpiW-1:0] width;
  logic [IdxW-1:0] mask;
  logic [BufW+ByteW-1:0] pushed;

  always_comb begin
    if (bits_per_index_i == '0) begin
      width = BpiW'(1);
    end else if (bits_per_index_i > BpiMax) begin
      width = BpiMax;
    end else begin
      width = bits_per_index_i;
    end
  end

  assign mask   = IdxW'((5'd1 << width) - 5'd1);
  assign pushed = {{BufW{1'b0}}, index_byte_i} << cnt_q[$clog2(BufW)-1:0];

  always_comb begin
    buf_d = buf_q;
    cnt_d = cnt_q;
    ctl_o = '{has_result: 1'b0, status: STATUS_OK, rd_en: 1'b0, idx: buf_q[IdxW-1:0] & mask};
    case (kind_i)
      KIND_PUSH: begin
        ctl_o.has_result = 1'b1;
        if (cnt_q > PushLimit) begin
          ctl_o.status = STATUS_REFUSED;
        end else begin
          buf_d = buf_q | pushed[BufW-1:0];
          cnt_d = cnt_q + CntW'(ByteW);
        end
      end
      KIND_EMIT: begin
        ctl_o.has_result = 1'b1;
        if (cnt_q < CntW'(width)) begin
          ctl_o.status = STATUS_SHORT;
        end else begin
          ctl_o.rd_en = 1'b1;
          buf_d = buf_q >> width;
          cnt_d = cnt_q - CntW'(width);
        end
      end
      KIND_CLEAR: begin
        buf_d = '0;
        cnt_d = '0;
      end
      default: begin
        buf_d = buf_q;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      buf_q <= '0;
      cnt_q <= '0;
    end else if (accept_i) begin
      buf_q <= buf_d;
      cnt_q <= cnt_d;
    end
  end

endmodule

// ----- sv/pie_checker.sv -----
`include "palette_index_pixel_expander_defines.svh"

module pie_checker
  import pie_pkg::*;
(
  input logic      clk_i,
  input logic      rst_ni,
  input logic      in_ready_o,
  input logic      out_valid_o,
  input logic      out_ready_i,
  input out_item_t out_item_o
);

  logic out_err;
  logic out_stalled;

  assign out_err     = out_valid_o && (out_item_o.status != STATUS_OK);
  assign out_stalled = out_valid_o && !out_ready_i;

  `PIE_ASSERT_ALWAYS(a_no_out_in_reset, !rst_ni |=> !out_valid_o, "item shown during reset")

  `PIE_ASSERT(a_error_zero_pixel, out_err |-> out_item_o.pixel_word == '0, "error item with pixel")

  `PIE_ASSERT(a_stall_only_when_full, !in_ready_o |-> out_valid_o, "input stalled with output empty")

  `PIE_ASSERT(a_out_hold, out_stalled |=> out_valid_o && $stable(out_item_o), "stalled item changed")

endmodule

bind palette_index_pixel_expander pie_checker u_pie_checker (.*);
